>>> rtl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

  // Command codes carried in the input word
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Input word: a table load or an allocation request
  typedef struct packed {
    logic        command;
    logic [15:0] item_id;
    logic [15:0] item_size;
  } in_word_t;

  // Result word: the answer to one allocation request
  typedef struct packed {
    logic [15:0] request_id;
    logic        granted;
    logic [15:0] block_label;
    logic [3:0]  block_index;
    logic [15:0] space_left;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_we;   // append the input word to the table
    logic req_cap;   // capture request id and size, rewind the read pointer
    logic rd_en;     // read the entry at the read pointer and advance it
    logic wb_we;     // write the reduced size back to the compared entry
    logic emit;      // load the result register
    logic grant;     // the result carries a granted block
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;     // no entry loaded
    logic full;      // table at capacity
    logic fits;      // request fits the entry under comparison
    logic last;      // entry under comparison is the last loaded one
  } dp_status_t;

endpackage

>>> rtl/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
// Load word: taken while idle without raising busy, so loads may follow back to back.
// Request word: busy in the fetch state, then in the scan state until entry k fits or
// none of n entries fits; an empty table ends in fetch. One table entry is compared per cycle.
// The result strobe shows in the cycle in which busy falls; a new word may start then.
// Reset clears the fill count and control; the table contents are not cleared.

module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word_i,
  output logic      result_valid_o,
  output out_word_t result_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  ffba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (in_word_i.command),
    .status_i  (dp_status),
    .cmd_o     (dp_cmd),
    .busy      (busy)
  );

  ffba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_word_i      (in_word_i),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

`ifndef SYNTHESIS
  // The result strobe is never high on consecutive cycles
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe on two consecutive cycles");

  // Write back only into an entry that fits
  a_wb_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.wb_we |-> (dp_status.fits && dp_cmd.emit && dp_cmd.grant))
    else $error("write-back without a fitting entry");

  // A refused request carries zero fields
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.granted) |->
      (result_o.block_label == 16'd0 && result_o.block_index == 4'd0 &&
       result_o.space_left == 16'd0))
    else $error("refused result with non-zero fields");

  // An accepted request makes the unit busy
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_word_i.command == CMD_ALLOC) |=> busy)
    else $error("request accepted without going busy");
`endif

endmodule

>>> rtl/ffba_ctrl.sv
`timescale 1ns / 1ps

module ffba_ctrl import ffba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       command_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;

  // Decode commands and the next state
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (command_i == CMD_ALLOC) begin
            cmd_o.req_cap = 1'b1;
            state_d       = ST_FETCH;
          end else begin
            cmd_o.load_we = !status_i.full;
          end
        end
      end
      ST_FETCH: begin
        if (status_i.empty) begin
          // nothing loaded: answer not granted at once
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.fits) begin
          cmd_o.wb_we = 1'b1;
          cmd_o.emit  = 1'b1;
          cmd_o.grant = 1'b1;
          state_d     = ST_IDLE;
        end else if (status_i.last) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/ffba_datapath.sv
`timescale 1ns / 1ps

module ffba_datapath import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_word_t   in_word_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       result_valid_o,
  output out_word_t  result_o
);

  localparam int IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CntW = $clog2(MAX_BLOCKS + 1);

  // Block table
  logic [SIZE_BITS-1:0] size_mem  [MAX_BLOCKS];
  logic [15:0]          label_mem [MAX_BLOCKS];

  logic [CntW-1:0]      cnt_q;
  logic [IdxW-1:0]      rd_ptr_q;
  logic [IdxW-1:0]      cmp_ptr_q;
  logic [SIZE_BITS-1:0] rd_size_q;
  logic [15:0]          rd_label_q;
  logic [15:0]          req_id_q;
  logic [SIZE_BITS-1:0] req_size_q;
  logic                 res_valid_q;
  out_word_t            res_q;
  logic [SIZE_BITS-1:0] diff;

  assign diff = rd_size_q - req_size_q;

  // Status towards the controller
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(MAX_BLOCKS));
  assign status_o.fits  = (req_size_q <= rd_size_q);
  assign status_o.last  = ((CntW'(cmp_ptr_q) + CntW'(1)) == cnt_q);

  // Write the table, read one entry per scan step
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      size_mem[cnt_q[IdxW-1:0]]  <= SIZE_BITS'(in_word_i.item_size);
      label_mem[cnt_q[IdxW-1:0]] <= in_word_i.item_id;
    end
    if (cmd_i.wb_we) begin
      size_mem[cmp_ptr_q] <= diff;
    end
    if (cmd_i.rd_en) begin
      rd_size_q  <= size_mem[rd_ptr_q];
      rd_label_q <= label_mem[rd_ptr_q];
      cmp_ptr_q  <= rd_ptr_q;
    end
  end

  // Capture the request and load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_cap) begin
      req_id_q   <= in_word_i.item_id;
      req_size_q <= SIZE_BITS'(in_word_i.item_size);
    end
    if (cmd_i.emit) begin
      res_q.request_id  <= req_id_q;
      res_q.granted     <= cmd_i.grant;
      res_q.block_label <= cmd_i.grant ? rd_label_q : 16'd0;
      res_q.block_index <= cmd_i.grant ? 4'(cmp_ptr_q) : 4'd0;
      res_q.space_left  <= cmd_i.grant ? 16'(diff) : 16'd0;
    end
  end

  // Fill count, read pointer and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
      if (cmd_i.load_we) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.req_cap) begin
        rd_ptr_q <= '0;
      end else if (cmd_i.rd_en) begin
        rd_ptr_q <= rd_ptr_q + IdxW'(1);
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
